### rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, command codes and store port bundle for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

   // store geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int WORD_W = 32;

   // command codes, six and seven behave as status
   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_CLEAR      = 3'd4,
      CMD_STATUS     = 3'd5
   } cmd_type;

   // fault codes
   localparam logic [1:0] FAULT_OK    = 2'd0;
   localparam logic [1:0] FAULT_FULL  = 2'd1;
   localparam logic [1:0] FAULT_EMPTY = 2'd2;

   // one write port and one read port of the word store
   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [WORD_W-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_addr;
   } store_req_type;

   // circular wrap of a sum known to stay below twice the depth
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      begin
         r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
         wrap_idx = r[IDX_W-1:0];
      end
   endfunction

   function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
      inc_idx = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] i);
      dec_idx = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
   endfunction

endpackage

### rtl/bdq_store.sv
// ----------------------------------------------------------------------------
// bdq_store
// Word store of the deque: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_store import bdq_pkg::*; (
   input  logic                     clock,
   input  store_req_type            req,
   output logic signed [WORD_W-1:0] rd_data
);

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   // read port, data registered and ready in the cycle after the address
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit words over a circular store.
// ----------------------------------------------------------------------------
// Usage
//   Input channel req_*: a command (push front, push back, pop front,
//   pop back, clear, status) and a word to push. Every transaction yields
//   exactly one rsp_* transaction: the popped word, the front and rear words
//   after the command, the count, empty and full flags and a fault code.
//   Push, clear and status results go from the DONE state into the output
//   register; a pop that leaves words behind first passes the FETCH state,
//   since the new front or rear word is fetched from the store, whose read
//   port is registered. One command is worked at a time, and no new
//   transaction is taken until the last one has left the DONE state.
//   The front and rear words are kept in registers, so each command needs
//   at most one store write or one store read.
//   Reset leaves the deque empty with the head at entry zero; the store is
//   not cleared, entries are read only after a push wrote them.
//   A stalled result stays in the output register; the next command is
//   still accepted and worked, and waits for the register to free.
// ----------------------------------------------------------------------------
module bounded_deque import bdq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_cmd,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_popped,
   output logic signed [WORD_W-1:0] rsp_front_word,
   output logic signed [WORD_W-1:0] rsp_rear_word,
   output logic [CNT_W-1:0]         rsp_occupancy,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full,
   output logic [1:0]               rsp_fault
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         held_ff, held_in;
   logic signed [WORD_W-1:0] front_ff, front_in;
   logic signed [WORD_W-1:0] rear_ff, rear_in;
   logic signed [WORD_W-1:0] popped_ff, popped_in;
   logic [1:0]               fault_ff, fault_in;
   logic                     fetch_front_ff, fetch_front_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_popped_ff, rsp_popped_in;
   logic signed [WORD_W-1:0] rsp_front_ff, rsp_front_in;
   logic signed [WORD_W-1:0] rsp_rear_ff, rsp_rear_in;
   logic [CNT_W-1:0]         rsp_occ_ff, rsp_occ_in;
   logic [1:0]               rsp_fault_ff, rsp_fault_in;

   store_req_type            store_req;
   logic signed [WORD_W-1:0] store_rd_data;
   logic                     is_empty, is_full;

   assign is_empty = (held_ff == '0);
   assign is_full  = (held_ff == CNT_W'(DEPTH));

   // word store
   bdq_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (store_rd_data)
   );

   // command sequencer and result register
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      held_in        = held_ff;
      front_in       = front_ff;
      rear_in        = rear_ff;
      popped_in      = popped_ff;
      fault_in       = fault_ff;
      fetch_front_in = fetch_front_ff;
      rsp_popped_in  = rsp_popped_ff;
      rsp_front_in   = rsp_front_ff;
      rsp_rear_in    = rsp_rear_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_fault_in   = rsp_fault_ff;
      store_req      = '0;

      // result taken by the receiver
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               popped_in = '0;
               fault_in  = FAULT_OK;
               state_in  = ST_DONE;
               case (cmd_type'(req_cmd))
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        fault_in = FAULT_FULL;
                     end else begin
                        head_in           = dec_idx(head_ff);
                        held_in           = held_ff + CNT_W'(1);
                        front_in          = req_value;
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = dec_idx(head_ff);
                        store_req.wr_data = req_value;
                        if (is_empty) begin
                           rear_in = req_value;
                        end
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (is_full) begin
                        fault_in = FAULT_FULL;
                     end else begin
                        held_in           = held_ff + CNT_W'(1);
                        rear_in           = req_value;
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = wrap_idx(SUM_W'(head_ff) + SUM_W'(held_ff));
                        store_req.wr_data = req_value;
                        if (is_empty) begin
                           front_in = req_value;
                        end
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_empty) begin
                        fault_in = FAULT_EMPTY;
                     end else begin
                        popped_in = front_ff;
                        head_in   = inc_idx(head_ff);
                        held_in   = held_ff - CNT_W'(1);
                        if (held_ff == CNT_W'(1)) begin
                           front_in = '0;
                           rear_in  = '0;
                        end else begin
                           store_req.rd_en   = 1'b1;
                           store_req.rd_addr = inc_idx(head_ff);
                           fetch_front_in    = 1'b1;
                           state_in          = ST_FETCH;
                        end
                     end
                  end
                  CMD_POP_BACK: begin
                     if (is_empty) begin
                        fault_in = FAULT_EMPTY;
                     end else begin
                        popped_in = rear_ff;
                        held_in   = held_ff - CNT_W'(1);
                        if (held_ff == CNT_W'(1)) begin
                           front_in = '0;
                           rear_in  = '0;
                        end else begin
                           store_req.rd_en   = 1'b1;
                           store_req.rd_addr = wrap_idx(SUM_W'(head_ff) + SUM_W'(held_ff)
                                                        - SUM_W'(2));
                           fetch_front_in    = 1'b0;
                           state_in          = ST_FETCH;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     head_in  = '0;
                     held_in  = '0;
                     front_in = '0;
                     rear_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // new end word arrives from the store
         ST_FETCH: begin
            if (fetch_front_ff) begin
               front_in = store_rd_data;
            end else begin
               rear_in = store_rd_data;
            end
            state_in = ST_DONE;
         end
         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = popped_ff;
               rsp_front_in  = front_ff;
               rsp_rear_in   = rear_ff;
               rsp_occ_in    = held_ff;
               rsp_fault_in  = fault_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         held_ff      <= '0;
         front_ff     <= '0;
         rear_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         held_ff      <= held_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      popped_ff      <= popped_in;
      fault_ff       <= fault_in;
      fetch_front_ff <= fetch_front_in;
      rsp_popped_ff  <= rsp_popped_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_rear_ff    <= rsp_rear_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_fault_ff   <= rsp_fault_in;
   end

   // ports
   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_popped     = rsp_popped_ff;
   assign rsp_front_word = rsp_front_ff;
   assign rsp_rear_word  = rsp_rear_ff;
   assign rsp_occupancy  = rsp_occ_ff;
   assign rsp_is_empty   = (rsp_occ_ff == '0);
   assign rsp_is_full    = (rsp_occ_ff == CNT_W'(DEPTH));
   assign rsp_fault      = rsp_fault_ff;

endmodule

### rtl/bdq_check.sv
// ----------------------------------------------------------------------------
// bdq_check
// Port-level checks of the bounded deque results, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_check import bdq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [WORD_W-1:0] rsp_popped,
   input logic signed [WORD_W-1:0] rsp_front_word,
   input logic signed [WORD_W-1:0] rsp_rear_word,
   input logic [CNT_W-1:0]         rsp_occupancy,
   input logic                     rsp_is_empty,
   input logic                     rsp_is_full,
   input logic [1:0]               rsp_fault
);

   // count never beyond the store depth
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CNT_W'(DEPTH)))
      else $error("occupancy beyond depth");

   // an empty deque shows zero end words
   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_front_word == '0 && rsp_rear_word == '0))
      else $error("end words not zero when empty");

   // a dropped push only happens on a full deque
   a_full_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fault == FAULT_FULL) |-> (rsp_is_full && rsp_popped == '0))
      else $error("push fault without full deque");

   // a failed pop only happens on an empty deque
   a_empty_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fault == FAULT_EMPTY) |-> (rsp_is_empty && rsp_popped == '0))
      else $error("pop fault without empty deque");

   // a stalled result holds its popped word, count and fault code
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_popped)
                                    && $stable(rsp_occupancy) && $stable(rsp_fault)))
      else $error("stalled result changed");

endmodule

bind bounded_deque bdq_check u_bdq_check (.*);
